[rtl/streamline_centroid_running_mean_unit_macros.svh]
// Assertion macros for the streamline centroid unit.
`ifndef STREAMLINE_CENTROID_RUNNING_MEAN_UNIT_MACROS_SVH
`define STREAMLINE_CENTROID_RUNNING_MEAN_UNIT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define SCRM_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication failed");
// plain invariant
`define SCRM_ASSERT_ALW(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("invariant failed");
`endif

[rtl/scrm_pkg.sv]
// Package of the streamline centroid unit: types and constants.
`timescale 1ns / 1ps
package scrm_pkg;
    localparam int MaxElements = 1024;
    localparam int IdxW = $clog2(MaxElements);
    localparam int LenW = 11;
    localparam int CountW = 16;
    localparam int DataW = 32;
    localparam int InW = 7 * DataW + LenW;
    localparam int OutW = 7 * DataW + IdxW + 1 + CountW;
    localparam int QDepth = 2;

    typedef struct packed {
        logic [DataW-1:0] px, py, pz, vx, vy, vz, rad;
        logic             reject;
        logic             first;
        logic [IdxW-1:0]  idx;
        logic [CountW-1:0] lines_before;
        logic [CountW-1:0] lines_after;
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_READ, ST_LOAD, ST_DIV, ST_ADD, ST_SQ, ST_SQRT, ST_WRITE, ST_OUT
    } be_state_t;
endpackage

[rtl/streamline_centroid_running_mean_unit.sv]
// Steps: a rejected element passes ST_READ and ST_OUT; a first-line element ST_READ, ST_WRITE
// and ST_OUT; later elements add six 33-step serial divisions by the line count and a 32-step
// integer root. One element at a time through the back end: it takes a new one only when idle
// and its last output has been taken; a 2-entry queue decouples the input.
// Reset: rst_n asynchronous active low clears counters, length latch, queue and state;
// the centroid memories are not cleared.
`timescale 1ns / 1ps
module streamline_centroid_running_mean_unit (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // position_x, position_y, position_z, velocity_x, velocity_y, velocity_z,
    // element_radius, line_length, 5 zero pad bits
    input  logic [239:0]              s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // centroid_x, centroid_y, centroid_z, mean_velocity_x, mean_velocity_y,
    // mean_velocity_z, centroid_radius_out, element_number, status, lines_in_bundle, pad
    output logic [255:0]              m_axis_tdata
);
    import scrm_pkg::*;
    logic            fq_valid, fq_ready, qb_valid, qb_ready;
    cmd_t            fq_cmd, qb_cmd;
    logic [OutW-1:0] odata;

    scrm_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_data(s_axis_tdata[InW-1:0]), .cmd_valid(fq_valid), .cmd_ready(fq_ready),
        .cmd(fq_cmd)
    );
    scrm_queue u_queue (
        .clk(clk), .rst_n(rst_n), .wr_valid(fq_valid), .wr_ready(fq_ready),
        .wr_data(fq_cmd), .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_data(qb_cmd)
    );
    scrm_back u_back (
        .clk(clk), .rst_n(rst_n), .cmd_valid(qb_valid), .cmd_ready(qb_ready), .cmd(qb_cmd),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(odata)
    );
    assign m_axis_tdata = {{(256-OutW){1'b0}}, odata};
endmodule

[rtl/scrm_ram.sv]
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module scrm_ram #(
    parameter int Width = 32,
    parameter int Depth = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] addr,
    input  logic [Width-1:0]         wdata,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

[rtl/scrm_front.sv]
// Front end: checks the line length, tracks element and line counters, issues commands.
`timescale 1ns / 1ps
module scrm_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [scrm_pkg::InW-1:0]  in_data,
    output logic                      cmd_valid,
    input  logic                      cmd_ready,
    output scrm_pkg::cmd_t            cmd
);
    import scrm_pkg::*;
    logic [LenW-1:0]   len_reg, len_next, len;
    logic [CountW-1:0] lines_reg, lines_next;
    logic [IdxW:0]     idx_reg, idx_next;
    logic              rej, fire;

    assign len = in_data[InW-1 -: LenW];
    assign in_ready = cmd_ready;
    assign cmd_valid = in_valid;
    assign fire = in_valid && cmd_ready;

    always_comb
    begin
        len_next = len_reg;
        if (lines_reg == '0 && idx_reg == '0 && len >= LenW'(1) && len <= LenW'(MaxElements))
        begin
            len_next = len;
        end
        rej = (len == '0) || (len > LenW'(MaxElements)) || (len != len_next)
            || (idx_reg >= (IdxW+1)'(MaxElements));
        idx_next = idx_reg;
        lines_next = lines_reg;
        if (!rej)
        begin
            if ((LenW+1)'(idx_reg) + (LenW+1)'(1) >= (LenW+1)'(len_next))
            begin
                idx_next = '0;
                if (lines_reg != '1)
                begin
                    lines_next = lines_reg + CountW'(1);
                end
            end
            else
            begin
                idx_next = idx_reg + (IdxW+1)'(1);
            end
        end
        cmd.px = in_data[0*DataW +: DataW];
        cmd.py = in_data[1*DataW +: DataW];
        cmd.pz = in_data[2*DataW +: DataW];
        cmd.vx = in_data[3*DataW +: DataW];
        cmd.vy = in_data[4*DataW +: DataW];
        cmd.vz = in_data[5*DataW +: DataW];
        cmd.rad = in_data[6*DataW +: DataW];
        cmd.reject = rej;
        cmd.first = (lines_reg == '0);
        cmd.idx = idx_reg[IdxW-1:0];
        cmd.lines_before = lines_reg;
        cmd.lines_after = lines_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
            lines_reg <= '0;
            idx_reg <= '0;
        end
        else if (fire)
        begin
            len_reg <= len_next;
            lines_reg <= lines_next;
            idx_reg <= idx_next;
        end
    end

`include "streamline_centroid_running_mean_unit_macros.svh"
    `SCRM_ASSERT_ALW(a_idx_range, idx_reg < (IdxW+1)'(MaxElements))
    `SCRM_ASSERT_IMP(a_lines_mono, fire, lines_next >= lines_reg)
    `SCRM_ASSERT_IMP(a_rej_hold, fire && rej, idx_next == idx_reg && lines_next == lines_reg)
endmodule

[rtl/scrm_queue.sv]
// Small command queue between front and back end.
`timescale 1ns / 1ps
module scrm_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_valid,
    output logic           wr_ready,
    input  scrm_pkg::cmd_t wr_data,
    output logic           rd_valid,
    input  logic           rd_ready,
    output scrm_pkg::cmd_t rd_data
);
    import scrm_pkg::*;
    localparam int PtrW = $clog2(QDepth);
    cmd_t            slot_reg [QDepth];
    logic [PtrW-1:0] wp_reg, rp_reg;
    logic [PtrW:0]   cnt_reg;
    logic            wr, rd;

    assign wr_ready = cnt_reg != (PtrW+1)'(QDepth);
    assign rd_valid = cnt_reg != '0;
    assign rd_data = slot_reg[rp_reg];
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            slot_reg[wp_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr) wp_reg <= (wp_reg == PtrW'(QDepth-1)) ? '0 : wp_reg + PtrW'(1);
            if (rd) rp_reg <= (rp_reg == PtrW'(QDepth-1)) ? '0 : rp_reg + PtrW'(1);
            cnt_reg <= cnt_reg + (PtrW+1)'(wr) - (PtrW+1)'(rd);
        end
    end
endmodule

[rtl/scrm_back.sv]
// Back end: memory update with serial divider and serial square root.
`timescale 1ns / 1ps
module scrm_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cmd_valid,
    output logic                      cmd_ready,
    input  scrm_pkg::cmd_t            cmd,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [scrm_pkg::OutW-1:0] out_data
);
    import scrm_pkg::*;
    localparam int NumW = DataW + 1;

    be_state_t         st_reg, st_next;
    cmd_t              c_reg;
    logic [2:0]        lane_reg, lane_next;
    logic [5:0]        bit_reg, bit_next;
    logic [DataW-1:0]  old_reg [7];
    logic [NumW-1:0]   q_reg, q_next, r_reg, r_next;
    logic              neg_reg, neg_next;
    logic [DataW-1:0]  res_reg [7];
    logic [2*NumW-1:0] sq_reg, sq_next;
    logic [DataW-1:0]  root_reg, root_next;
    logic [OutW-1:0]   ob_reg, ob_next;
    logic              ov_reg, ov_next;
    logic [DataW-1:0]  rdata [7];
    logic [DataW-1:0]  wdata [7];
    logic              we;
    logic [NumW:0]     diff;
    logic [NumW-1:0]   mag, dq, rsh;
    logic [CountW:0]   divisor;
    logic [DataW-1:0]  cand, half;
    logic [63:0]       csq;
    logic [DataW-1:0]  dabs;
    logic [DataW-1:0]  newv;
    logic [DataW-1:0]  ins [7];

    assign ins[0] = c_reg.px; assign ins[1] = c_reg.py; assign ins[2] = c_reg.pz;
    assign ins[3] = c_reg.vx; assign ins[4] = c_reg.vy; assign ins[5] = c_reg.vz;
    assign ins[6] = c_reg.rad;

    for (genvar g = 0; g < 7; g++)
    begin : g_mem
        scrm_ram #(.Width(DataW), .Depth(MaxElements)) u_ram (
            .clk(clk), .we(we), .addr(c_reg.idx), .wdata(wdata[g]), .rdata(rdata[g])
        );
    end

    assign divisor = {1'b0, c_reg.lines_before} + (CountW+1)'(1);
    assign half = root_reg >> 1;
    always_comb
    begin
        for (int k = 0; k < 6; k++)
        begin
            wdata[k] = c_reg.first ? ins[k] : res_reg[k];
        end
        wdata[6] = c_reg.first ? ins[6] : ((half > old_reg[6]) ? half : old_reg[6]);
    end

    assign cmd_ready = (st_reg == ST_IDLE) && !ov_reg;
    assign out_valid = ov_reg;
    assign out_data = ob_reg;

    always_comb
    begin
        st_next = st_reg;
        lane_next = lane_reg;
        bit_next = bit_reg;
        q_next = q_reg;
        r_next = r_reg;
        neg_next = neg_reg;
        sq_next = sq_reg;
        root_next = root_reg;
        ob_next = ob_reg;
        ov_next = ov_reg;
        we = 1'b0;
        diff = '0; mag = '0; rsh = '0; dq = '0; cand = '0; csq = '0; dabs = '0; newv = '0;
        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end
        case (st_reg)
            ST_IDLE:
            begin
                if (cmd_valid && cmd_ready)
                begin
                    st_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (c_reg.reject)
                begin
                    ob_next = {c_reg.lines_before, 1'b1, c_reg.idx, (7*DataW)'(0)};
                    st_next = ST_OUT;
                end
                else if (c_reg.first)
                begin
                    st_next = ST_WRITE;
                end
                else
                begin
                    st_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                lane_next = '0;
                sq_next = '0;
                st_next = ST_ADD;
            end
            ST_ADD:
            begin
                diff = {{2{ins[lane_reg][DataW-1]}}, ins[lane_reg]}
                     - {{2{old_reg[lane_reg][DataW-1]}}, old_reg[lane_reg]};
                neg_next = diff[NumW];
                mag = diff[NumW] ? NumW'(-diff) : diff[NumW-1:0];
                q_next = mag;
                r_next = '0;
                bit_next = 6'(NumW);
                st_next = ST_DIV;
            end
            ST_DIV:
            begin
                rsh = {r_reg[NumW-2:0], q_reg[NumW-1]};
                q_next = {q_reg[NumW-2:0], 1'b0};
                if ({1'b0, rsh} >= (NumW+1)'(divisor))
                begin
                    r_next = rsh - NumW'(divisor);
                    q_next[0] = 1'b1;
                end
                else
                begin
                    r_next = rsh;
                end
                bit_next = bit_reg - 6'(1);
                if (bit_reg == 6'(1))
                begin
                    st_next = ST_SQ;
                end
            end
            ST_SQ:
            begin
                dq = neg_reg ? NumW'(-q_reg) : q_reg;
                newv = old_reg[lane_reg] + dq[DataW-1:0];
                // divisor is at least two here, so the quotient fits in 31 bits
                dabs = q_reg[DataW-1:0];
                csq = dabs * dabs;
                if (lane_reg < 3'd3)
                begin
                    sq_next = sq_reg + (2*NumW)'(csq);
                end
                if (lane_reg == 3'd5)
                begin
                    root_next = '0;
                    bit_next = 6'd31;
                    st_next = ST_SQRT;
                end
                else
                begin
                    lane_next = lane_reg + 3'd1;
                    st_next = ST_ADD;
                end
            end
            ST_SQRT:
            begin
                cand = root_reg | (DataW'(1) << bit_reg[4:0]);
                csq = cand * cand;
                if ({2'b00, csq} <= sq_reg)
                begin
                    root_next = cand;
                end
                bit_next = bit_reg - 6'(1);
                if (bit_reg == '0)
                begin
                    st_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                we = 1'b1;
                ob_next = {c_reg.lines_after, 1'b0, c_reg.idx, wdata[6], wdata[5], wdata[4],
                           wdata[3], wdata[2], wdata[1], wdata[0]};
                st_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next = 1'b1;
                    st_next = ST_IDLE;
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid && cmd_ready)
        begin
            c_reg <= cmd;
        end
        if (st_reg == ST_LOAD)
        begin
            for (int k = 0; k < 7; k++)
            begin
                old_reg[k] <= rdata[k];
            end
        end
        if (st_reg == ST_SQ)
        begin
            res_reg[lane_reg] <= newv;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        neg_reg <= neg_next;
        sq_reg <= sq_next;
        root_reg <= root_next;
        ob_reg <= ob_next;
        lane_reg <= lane_next;
        bit_reg <= bit_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_IDLE;
            ov_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            ov_reg <= ov_next;
        end
    end

`include "streamline_centroid_running_mean_unit_macros.svh"
    `SCRM_ASSERT_IMP(a_hold_out, out_valid && !out_ready, ##1 out_valid && $stable(out_data))
    `SCRM_ASSERT_IMP(a_no_write_reject, we, !c_reg.reject)
    `SCRM_ASSERT_IMP(a_lane_range, st_reg == ST_ADD, lane_reg < 3'd6)
endmodule
